[hdl/fssp_pkg.sv]
// ----------------------------------------------------------------------------
// fssp_pkg: shared types and constants of the fan soft-start ramp
// Level scale, reciprocal constants, datapath operations and status bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package fssp_pkg;

   // level format: 1/256 percent units
   localparam int LEVEL_W    = 15;
   localparam int START_W    = 7;
   localparam int DUTY_W     = 9;
   localparam int MUL_W      = 24;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int DUTY_FULL_W = 17;

   localparam logic [LEVEL_W-1:0] FULL_SCALE = 15'd25600;
   localparam logic [LEVEL_W-1:0] ONE_PCT    = 15'd256;
   localparam logic [LEVEL_W-1:0] HALF_LEVEL = 15'd12800;
   // largest old target still counted as stopped (10 * t < 256)
   localparam logic [LEVEL_W-1:0] KICK_MAX   = 15'd25;
   localparam logic [START_W-1:0] START_MAX  = 7'd100;

   // reciprocal of 10, exact for values below 2^15
   localparam logic [MUL_W-1:0] RECIP10        = 24'd52429;
   localparam int               RECIP10_SHIFT  = 19;
   // reciprocal of 100, exact for products of level and percent
   localparam logic [MUL_W-1:0] RECIP100_A     = 24'd2684355;
   localparam int               RECIP100_A_SHIFT = 28;
   localparam int               SCALED_W       = 22;
   // reciprocal of 100, exact for drive * period / 256
   localparam logic [MUL_W-1:0] RECIP100_B     = 24'd10737419;
   localparam int               RECIP100_B_SHIFT = 30;
   localparam int               PRE_SHIFT      = 8;
   localparam int               PRE_W          = 23;

   // datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE       = 4'd0,
      OP_SET        = 4'd1,
      OP_MUL_GAP    = 4'd2,
      OP_UPDATE     = 4'd3,
      OP_MUL_SCALE  = 4'd4,
      OP_MUL_DIV1   = 4'd5,
      OP_LOAD_DRIVE = 4'd6,
      OP_MUL_PERIOD = 4'd7,
      OP_MUL_DIV2   = 4'd8,
      OP_LOAD_RSP   = 4'd9
   } op_type;

   // status from datapath to controller
   typedef struct packed {
      logic far;
      logic duty_ok;
   } status_type;

endpackage

`default_nettype wire

[hdl/fssp_dp.sv]
// ----------------------------------------------------------------------------
// fssp_dp: ramp datapath
// Target and level registers, start offset, one shared multiplier with a
// product register, drive register and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fssp_dp #(
   parameter int PWM_PERIOD = 333
) (
   input  wire                               clock,
   input  wire                               reset,
   input  fssp_pkg::op_type                  op,
   input  wire  [fssp_pkg::LEVEL_W-1:0]      req_target_level,
   input  wire                               csr_wr_en,
   input  wire  [fssp_pkg::START_W-1:0]      csr_wr_data,
   output fssp_pkg::status_type              status,
   output logic [fssp_pkg::DUTY_W-1:0]       rsp_duty_counts
);
   import fssp_pkg::*;

   localparam logic [DUTY_FULL_W-1:0] PERIOD       = DUTY_FULL_W'(PWM_PERIOD);
   localparam logic [DUTY_FULL_W-1:0] PERIOD_TENTH = DUTY_FULL_W'(PWM_PERIOD / 10);

   logic [LEVEL_W-1:0]  target_ff, target_in;
   logic [LEVEL_W-1:0]  level_ff, level_in;
   logic [START_W-1:0]  start_ff;
   logic                neg_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [LEVEL_W-1:0]  drive_ff;
   logic [DUTY_W-1:0]   rsp_duty_ff;

   logic [START_W-1:0]  start_sat;
   logic                neg;
   logic [LEVEL_W-1:0]  mag;
   logic [LEVEL_W-1:0]  t_sat;
   logic [LEVEL_W-1:0]  step;
   logic [LEVEL_W-1:0]  drive_in;
   logic [DUTY_FULL_W-1:0] duty;
   logic [MUL_W-1:0]    mul_a, mul_b;
   logic                mul_en;

   // start offset, values above 100 taken as 100
   assign start_sat = (start_ff > START_MAX) ? START_MAX : start_ff;

   // gap between target and level
   assign neg = target_ff < level_ff;
   assign mag = neg ? (level_ff - target_ff) : (target_ff - level_ff);

   // saturated new target
   assign t_sat = (req_target_level > FULL_SCALE) ? FULL_SCALE : req_target_level;

   // tenth of the gap from the reciprocal product
   assign step = prod_ff[RECIP10_SHIFT +: LEVEL_W];

   // drive level: scaled level plus offset, zero when the level is at or below 1% (fan off)
   assign drive_in = (level_ff > ONE_PCT)
                   ? LEVEL_W'(prod_ff[RECIP100_A_SHIFT +: LEVEL_W]
                              + {start_sat, 8'd0})
                   : '0;

   // duty counts after the second divide by 100
   assign duty = prod_ff[RECIP100_B_SHIFT +: DUTY_FULL_W];

   assign status.far     = mag > ONE_PCT;
   assign status.duty_ok = (duty + PERIOD_TENTH) < PERIOD;

   // multiplier operand select
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_en = 1'b1;
      unique case (op)
         OP_MUL_GAP: begin
            mul_a = MUL_W'(mag);
            mul_b = RECIP10;
         end
         OP_MUL_SCALE: begin
            mul_a = MUL_W'(level_ff);
            mul_b = MUL_W'(START_MAX - start_sat);
         end
         OP_MUL_DIV1: begin
            mul_a = MUL_W'(prod_ff[SCALED_W-1:0]);
            mul_b = RECIP100_A;
         end
         OP_MUL_PERIOD: begin
            mul_a = MUL_W'(drive_ff);
            mul_b = MUL_W'(PWM_PERIOD);
         end
         OP_MUL_DIV2: begin
            mul_a = MUL_W'(prod_ff[PRE_SHIFT +: PRE_W]);
            mul_b = RECIP100_B;
         end
         default: mul_en = 1'b0;
      endcase
   end

   // target and level next values
   always_comb begin
      target_in = target_ff;
      level_in  = level_ff;
      case (op)
         OP_SET: begin
            target_in = t_sat;
            if (target_ff <= KICK_MAX && t_sat > ONE_PCT) begin
               level_in = HALF_LEVEL;
            end
         end
         OP_UPDATE: begin
            level_in = neg_ff ? (level_ff - step) : (level_ff + step);
         end
         default: ;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         level_ff  <= '0;
         start_ff  <= '0;
      end else begin
         target_ff <= target_in;
         level_ff  <= level_in;
         if (csr_wr_en) begin
            start_ff <= csr_wr_data;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
      end
      if (op == OP_MUL_GAP) begin
         neg_ff <= neg;
      end
      if (op == OP_LOAD_DRIVE) begin
         drive_ff <= drive_in;
      end
      if (op == OP_LOAD_RSP) begin
         rsp_duty_ff <= duty[DUTY_W-1:0];
      end
   end

   assign rsp_duty_counts = rsp_duty_ff;

endmodule

`default_nettype wire

[hdl/fssp_ctrl.sv]
// ----------------------------------------------------------------------------
// fssp_ctrl: ramp sequencer
// Accepts requests, steps the datapath through the multiply chain of a tick
// and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module fssp_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire                   req_cmd,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   input  fssp_pkg::status_type  status,
   output fssp_pkg::op_type      op
);
   import fssp_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_STEP   = 8'b0000_0010,
      S_SCALE  = 8'b0000_0100,
      S_DIV1   = 8'b0000_1000,
      S_DRIVE  = 8'b0001_0000,
      S_PERIOD = 8'b0010_0000,
      S_DIV2   = 8'b0100_0000,
      S_EMIT   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // next state and datapath operation
   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (!req_cmd) begin
                  op = OP_SET;
               end else if (status.far) begin
                  op       = OP_MUL_GAP;
                  state_in = S_STEP;
               end
            end
         end
         S_STEP: begin
            op       = OP_UPDATE;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            op       = OP_MUL_SCALE;
            state_in = S_DIV1;
         end
         S_DIV1: begin
            op       = OP_MUL_DIV1;
            state_in = S_DRIVE;
         end
         S_DRIVE: begin
            op       = OP_LOAD_DRIVE;
            state_in = S_PERIOD;
         end
         S_PERIOD: begin
            op       = OP_MUL_PERIOD;
            state_in = S_DIV2;
         end
         S_DIV2: begin
            op       = OP_MUL_DIV2;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            // drop duty too close to the period, else wait for a free slot
            if (!status.duty_ok) begin
               state_in = S_IDLE;
            end else if (rsp_free) begin
               op       = OP_LOAD_RSP;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (op == OP_LOAD_RSP) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   // a far tick request starts the level update next cycle
   a_tick_starts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && req_cmd && status.far) |=> state_ff == S_STEP)
      else $error("far tick did not start the ramp step");

   // a result is loaded only for an acceptable duty
   a_load_ok: assert property (@(posedge clock) disable iff (reset)
      (op == OP_LOAD_RSP) |-> (state_ff == S_EMIT && status.duty_ok))
      else $error("result loaded outside emit or with duty too high");

   // a pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (op == OP_LOAD_RSP) |-> rsp_free)
      else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

[hdl/fan_soft_start_pwm_ramp.sv]
// ----------------------------------------------------------------------------
// fan_soft_start_pwm_ramp: fan drive soft-start ramp to PWM compare counts
// Usage:
//   req channel (valid/ready): req_cmd 0 sets a new target level (1/256 %),
//   req_cmd 1 is one ramp tick. Set requests never give a result.
//   rsp channel (valid/ready): rsp_duty_counts is the new PWM compare value.
//   csr_wr_en/csr_wr_data write start_percent; write only while idle.
// Sequence:
//   a set request, or a tick whose gap is within 1%, is done in the idle state
//   and gives no result. A tick that moves the level runs the sequencer through
//   8 states on one shared 24x24 multiplier (tenth of gap, scale, /100,
//   period, /100); a new request is taken only once it is back in idle.
//   A tick whose duty is too close to the period gives no result.
// Reset: synchronous; target, level and start offset return to zero.
// Stall: a result waits in the output register; the block still accepts the
//   next request and holds a new tick result in its last state until the
//   output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module fan_soft_start_pwm_ramp #(
   parameter int PWM_PERIOD = 333
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire                               req_cmd,
   input  wire  [fssp_pkg::LEVEL_W-1:0]      req_target_level,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic [fssp_pkg::DUTY_W-1:0]       rsp_duty_counts,
   input  wire                               csr_wr_en,
   input  wire  [fssp_pkg::START_W-1:0]      csr_wr_data
);
   import fssp_pkg::*;

   op_type     op;
   status_type status;

   // sequencer
   fssp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .op        (op)
   );

   // datapath
   fssp_dp #(
      .PWM_PERIOD (PWM_PERIOD)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .op               (op),
      .req_target_level (req_target_level),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .status           (status),
      .rsp_duty_counts  (rsp_duty_counts)
   );

endmodule

`default_nettype wire
